### hdl/mmblu_pkg.sv
package mmblu_pkg;

    localparam int INSTR_BYTES_DEF = 4096;
    localparam int DATA_BYTES_DEF  = 16384;
    localparam int NUM_REGS        = 8;
    localparam int CFG_AW          = 5;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_FETCH = 2'd3;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DATA  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;

    localparam logic [2:0] REG_INSTR_BASE = 3'd0;
    localparam logic [2:0] REG_DATA_BASE  = 3'd1;
    localparam logic [2:0] REG_GETC_WORD  = 3'd2;
    localparam logic [2:0] REG_GETC_HALF  = 3'd3;
    localparam logic [2:0] REG_GETC_BYTE  = 3'd4;
    localparam logic [2:0] REG_PUTC_WORD  = 3'd5;
    localparam logic [2:0] REG_PUTC_HALF  = 3'd6;
    localparam logic [2:0] REG_PUTC_BYTE  = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic [7:0]  console_char;
        logic        console_eof;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic [7:0]  out_char;
        logic        out_char_valid;
        logic        char_taken;
    } t_out_item;

    typedef enum logic [1:0] {
        K_DONE  = 2'd0,
        K_DATA  = 2'd1,
        K_INSTR = 2'd2
    } t_kind;

    // classified access handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        wr;
        logic [31:0] offset;
        logic [2:0]  nbytes;
        logic [31:0] wdata;
        t_out_item   res;
    } t_cmd;

endpackage

### hdl/memory_map_byte_lane_unit_core.sv
// Memory port with a big-endian memory map and console I/O. After reset both
// stores are swept to zero, one byte a cycle, and no access is taken until
// then. The front stage decodes each access combinationally into a register;
// the back end walks the byte-wide RAMs one byte per step, a read byte through
// S_ISSUE then S_WAIT, a written byte in S_ISSUE, and then S_OUT; console
// and error accesses go straight to S_OUT. Registers sit at byte address 4*i.
module memory_map_byte_lane_unit_core #(
    parameter int INSTR_BYTES = mmblu_pkg::INSTR_BYTES_DEF,
    parameter int DATA_BYTES  = mmblu_pkg::DATA_BYTES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  mmblu_pkg::t_in_item     i_item,
    output logic                    o_valid,
    input  logic                    i_stall,
    output mmblu_pkg::t_out_item    o_item,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [mmblu_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [31:0]     r_regs [mmblu_pkg::NUM_REGS];
    logic            cmd_valid, cmd_stall, busy, fstall;
    mmblu_pkg::t_cmd cmd;
    logic [2:0]      ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign prdata = (paddr[1:0] == 2'd0) ? r_regs[ridx] : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[mmblu_pkg::REG_INSTR_BASE] <= 32'h1000_0000;
            r_regs[mmblu_pkg::REG_DATA_BASE]  <= 32'h2000_0000;
            r_regs[mmblu_pkg::REG_GETC_WORD]  <= 32'h3000_0000;
            r_regs[mmblu_pkg::REG_GETC_HALF]  <= 32'h3000_0002;
            r_regs[mmblu_pkg::REG_GETC_BYTE]  <= 32'h3000_0003;
            r_regs[mmblu_pkg::REG_PUTC_WORD]  <= 32'h3000_0004;
            r_regs[mmblu_pkg::REG_PUTC_HALF]  <= 32'h3000_0006;
            r_regs[mmblu_pkg::REG_PUTC_BYTE]  <= 32'h3000_0007;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            r_regs[ridx] <= pwdata;
        end
    end

    // hold input off during the clearing sweep and while the front stage is stalled
    assign o_stall = fstall || busy;

    mmblu_front #(.INSTR_BYTES(INSTR_BYTES), .DATA_BYTES(DATA_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid && !busy),
        .o_stall(fstall), .i_item(i_item), .i_regs(r_regs),
        .o_cmd_valid(cmd_valid), .i_cmd_stall(cmd_stall), .o_cmd(cmd));

    mmblu_back #(.INSTR_BYTES(INSTR_BYTES), .DATA_BYTES(DATA_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_stall(cmd_stall), .i_cmd(cmd), .o_busy(busy),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item));
endmodule

### hdl/mmblu_ram.sv
module mmblu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/mmblu_front.sv
module mmblu_front #(
    parameter int INSTR_BYTES = mmblu_pkg::INSTR_BYTES_DEF,
    parameter int DATA_BYTES  = mmblu_pkg::DATA_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  mmblu_pkg::t_in_item  i_item,
    input  logic [31:0]          i_regs [mmblu_pkg::NUM_REGS],
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_stall,
    output mmblu_pkg::t_cmd      o_cmd
);
    logic            r_valid;
    mmblu_pkg::t_cmd r_cmd;
    mmblu_pkg::t_cmd n_cmd;
    logic [31:0] doff, ioff;
    logic        in_data, in_instr, getc, putc, ok_d, ok_i;
    logic [32:0] dend, iend;
    logic [2:0]  n;

    always_comb begin
        doff = i_item.address - i_regs[mmblu_pkg::REG_DATA_BASE];
        ioff = i_item.address - i_regs[mmblu_pkg::REG_INSTR_BASE];
        in_data  = {1'b0, doff} < 33'(DATA_BYTES);
        in_instr = {1'b0, ioff} < 33'(INSTR_BYTES);
        unique case (i_item.access_size)
            mmblu_pkg::SZ_BYTE: n = 3'd1;
            mmblu_pkg::SZ_HALF: n = 3'd2;
            default:            n = 3'd4;
        endcase
        dend = {1'b0, doff} + 33'(n);
        iend = {1'b0, ioff} + 33'(n);
        ok_d = (i_item.access_size != 2'd3) && (dend <= 33'(DATA_BYTES));
        ok_i = (i_item.access_size != 2'd3) && (iend <= 33'(INSTR_BYTES));
        getc = (i_item.address == i_regs[mmblu_pkg::REG_GETC_WORD]
                    && i_item.access_size == mmblu_pkg::SZ_WORD)
            || (i_item.address == i_regs[mmblu_pkg::REG_GETC_HALF]
                    && i_item.access_size == mmblu_pkg::SZ_HALF)
            || (i_item.address == i_regs[mmblu_pkg::REG_GETC_BYTE]
                    && i_item.access_size == mmblu_pkg::SZ_BYTE);
        putc = (i_item.address == i_regs[mmblu_pkg::REG_PUTC_WORD]
                    && i_item.access_size == mmblu_pkg::SZ_WORD)
            || (i_item.address == i_regs[mmblu_pkg::REG_PUTC_HALF]
                    && i_item.access_size == mmblu_pkg::SZ_HALF)
            || (i_item.address == i_regs[mmblu_pkg::REG_PUTC_BYTE]
                    && i_item.access_size == mmblu_pkg::SZ_BYTE);

        n_cmd        = '0;
        n_cmd.kind   = mmblu_pkg::K_DONE;
        n_cmd.wdata  = i_item.write_data;
        n_cmd.nbytes = n;
        unique case (i_item.op)
            mmblu_pkg::OP_READ: begin
                priority if (getc) begin
                    if (i_item.console_eof) begin
                        n_cmd.res.read_data = '1;
                    end else begin
                        n_cmd.res.read_data  = {24'd0, i_item.console_char};
                        n_cmd.res.char_taken = 1'b1;
                    end
                end else if (in_data) begin
                    if (ok_d) begin
                        n_cmd.kind = mmblu_pkg::K_DATA;
                        n_cmd.offset = doff;
                    end else begin
                        n_cmd.res.status = mmblu_pkg::ST_DATA;
                    end
                end else if (in_instr) begin
                    if (ok_i) begin
                        n_cmd.kind = mmblu_pkg::K_INSTR;
                        n_cmd.offset = ioff;
                    end else begin
                        n_cmd.res.status = mmblu_pkg::ST_DATA;
                    end
                end else begin
                    n_cmd.res.status = mmblu_pkg::ST_DATA;
                end
            end
            mmblu_pkg::OP_WRITE: begin
                priority if (putc) begin
                    n_cmd.res.out_char = i_item.write_data[7:0];
                    n_cmd.res.out_char_valid = 1'b1;
                end else if (in_data && ok_d) begin
                    n_cmd.kind = mmblu_pkg::K_DATA;
                    n_cmd.wr = 1'b1;
                    n_cmd.offset = doff;
                end else begin
                    n_cmd.res.status = mmblu_pkg::ST_DATA;
                end
            end
            mmblu_pkg::OP_LOAD: begin
                if (in_instr) begin
                    n_cmd.kind = mmblu_pkg::K_INSTR;
                    n_cmd.wr = 1'b1;
                    n_cmd.nbytes = 3'd1;
                    n_cmd.offset = ioff;
                end
            end
            default: begin
                if (in_instr && ({1'b0, ioff} + 33'd4 <= 33'(INSTR_BYTES))) begin
                    n_cmd.kind = mmblu_pkg::K_INSTR;
                    n_cmd.nbytes = 3'd4;
                    n_cmd.offset = ioff;
                end else begin
                    n_cmd.res.status = mmblu_pkg::ST_FETCH;
                end
            end
        endcase
    end

    assign o_stall     = r_valid && i_cmd_stall;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

### hdl/mmblu_back.sv
module mmblu_back #(
    parameter int INSTR_BYTES = mmblu_pkg::INSTR_BYTES_DEF,
    parameter int DATA_BYTES  = mmblu_pkg::DATA_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_stall,
    input  mmblu_pkg::t_cmd      i_cmd,
    output logic                 o_busy,
    output logic                 o_valid,
    input  logic                 i_stall,
    output mmblu_pkg::t_out_item o_item
);
    localparam int IAW = $clog2(INSTR_BYTES);
    localparam int DAW = $clog2(DATA_BYTES);
    localparam int CW  = (IAW > DAW) ? IAW : DAW;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ISSUE = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CW:0]          r_clr, n_clr;
    mmblu_pkg::t_cmd      r_cmd, n_cmd;
    logic [2:0]           r_idx, n_idx;
    logic [31:0]          r_acc, n_acc;
    mmblu_pkg::t_out_item r_out, n_out;
    logic                 r_ovalid, n_ovalid;

    logic           i_we, d_we;
    logic [IAW-1:0] i_addr;
    logic [DAW-1:0] d_addr;
    logic [7:0]     wbyte, i_rd, d_rd;
    logic [31:0]    addr;
    logic [4:0]     sh;

    mmblu_ram #(.WIDTH(8), .DEPTH(INSTR_BYTES)) u_iram (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_addr), .i_wdata(wbyte),
        .i_raddr(i_addr), .o_rdata(i_rd));
    mmblu_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dram (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_addr), .i_wdata(wbyte),
        .i_raddr(d_addr), .o_rdata(d_rd));

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_acc    = r_acc;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        i_we = 1'b0;
        d_we = 1'b0;
        addr = r_cmd.offset + 32'(r_idx);
        sh   = 5'((r_cmd.nbytes - 3'd1 - r_idx) * 8);
        wbyte = 8'(r_cmd.wdata >> sh);
        i_addr = addr[IAW-1:0];
        d_addr = addr[DAW-1:0];
        o_cmd_stall = 1'b1;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                // sweep both stores to zero after reset
                wbyte  = 8'd0;
                i_addr = r_clr[IAW-1:0];
                d_addr = r_clr[DAW-1:0];
                i_we   = r_clr < (CW+1)'(INSTR_BYTES);
                d_we   = r_clr < (CW+1)'(DATA_BYTES);
                n_clr  = r_clr + 1'b1;
                if (r_clr == (CW+1)'((INSTR_BYTES > DATA_BYTES) ? INSTR_BYTES - 1
                                                                : DATA_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd_stall = 1'b0;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    n_idx = 3'd0;
                    n_acc = '0;
                    n_state = (i_cmd.kind == mmblu_pkg::K_DONE) ? S_OUT : S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_cmd.wr) begin
                    i_we = r_cmd.kind == mmblu_pkg::K_INSTR;
                    d_we = r_cmd.kind == mmblu_pkg::K_DATA;
                    n_idx = r_idx + 3'd1;
                    if (r_idx + 3'd1 == r_cmd.nbytes) begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_acc = {r_acc[23:0],
                         (r_cmd.kind == mmblu_pkg::K_INSTR) ? i_rd : d_rd};
                n_idx = r_idx + 3'd1;
                if (r_idx + 3'd1 == r_cmd.nbytes) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_out = r_cmd.res;
                    if (r_cmd.kind != mmblu_pkg::K_DONE && !r_cmd.wr) begin
                        n_out.read_data = r_acc;
                    end
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;
    assign o_busy  = r_state == S_CLEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_acc <= n_acc;
        r_out <= n_out;
    end
endmodule
